### sv/mqpf_pkg.sv
// ----------------------------------------------------------------------------
// mqpf_pkg
// types and constants shared by the mqtt publish packet framer
// ----------------------------------------------------------------------------
package mqpf_pkg;

    // input item and result item
    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] topic_bytes;
        logic [27:0] payload_bytes;
        logic        retained;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
        logic [1:0] status;
    } result_t;

    // action codes
    localparam logic [1:0] ACT_START = 2'd0;
    localparam logic [1:0] ACT_DATA  = 2'd1;
    localparam logic [1:0] ACT_DISC  = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_LONG  = 2'd2;
    localparam logic [1:0] ST_SEQ   = 2'd3;

    // register index of buffer_limit
    localparam logic REG_BUFFER_LIMIT = 1'b0;

    localparam logic [28:0] RL_MAX       = 29'd268435455;
    localparam logic [28:0] LIMIT_RESET  = 29'd1460;
    localparam logic [7:0]  HDR_PUBLISH  = 8'h30;
    localparam logic [7:0]  HDR_DISC     = 8'hE0;
    localparam logic [28:0] RL_ONE_BYTE  = 29'd128;
    localparam logic [28:0] RL_TWO_BYTE  = 29'd16384;
    localparam logic [28:0] RL_THREE_BYTE = 29'd2097152;

    // depth of the command queue between front and back
    localparam int CMD_DEPTH = 4;

    typedef enum logic [1:0] {
        CMD_DATA,
        CMD_ERR,
        CMD_DISC,
        CMD_START
    } cmd_kind_t;

    // one classified command for the back end
    typedef struct packed {
        cmd_kind_t   kind;
        logic [7:0]  dbyte;      // data byte, or retain flag in bit 0 for start
        logic        last;
        logic [1:0]  status;
        logic [27:0] rem;        // remaining length
        logic [1:0]  nlen_m1;    // remaining length byte count minus one
        logic [15:0] topic_bytes;
    } cmd_t;

endpackage

### sv/mqtt_publish_packet_framer.sv
// ----------------------------------------------------------------------------
// mqtt_publish_packet_framer
// frames mqtt 3.1.1 publish (qos 0) and disconnect packets into bytes
// ----------------------------------------------------------------------------
// usage
//   input queue: push an item while full is low; action selects start,
//   data byte or disconnect, the other fields are read as needed
//   result queue: while empty is low the oldest byte is on result, pop
//   takes it; last marks a packet end or an error result
//   config: apb write of buffer_limit at byte address 0, pready tied high
// throughput
//   an item's first result passes the command queue and the output register
//   data items sustain one per cycle unless pop stalls; a start item yields
//   4 to 7 bytes, a disconnect 2, so the byte sequencer in the back end sets
//   the rate while it expands headers; the 4-entry command queue absorbs that
// reset
//   no packet open, queues empty, buffer_limit back to 1460
// stall
//   a held result stays on the ports; the command queue fills, then
//   full rises and holds off further items
// ----------------------------------------------------------------------------
module mqtt_publish_packet_framer
    import mqpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // item queue side
    input  logic        push,
    output logic        full,
    input  item_t       item,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output result_t     result,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [28:0] limit_reg;
    logic        cfg_wr;
    logic        item_valid;
    logic        cmd_push;
    cmd_t        cmd_in;
    cmd_t        cmd_head;
    logic        cmd_pop;
    logic        q_full;
    logic        q_empty;

    // register write on the access cycle, index from address bit 2
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[2] == REG_BUFFER_LIMIT) ? {3'b0, limit_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (cfg_wr && paddr[2] == REG_BUFFER_LIMIT)
            limit_reg <= pwdata[28:0];
    end

    // item transfer
    assign full       = q_full;
    assign item_valid = push && !q_full;

    // front: check and classify each item
    mqpf_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item         (item),
        .buffer_limit (limit_reg),
        .cmd_push     (cmd_push),
        .cmd          (cmd_in)
    );

    // decoupling queue
    mqpf_cmd_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cmd_push),
        .wr_data (cmd_in),
        .rd_en   (cmd_pop),
        .rd_data (cmd_head),
        .full    (q_full),
        .empty   (q_empty)
    );

    // back: byte sequencer and output register
    mqpf_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!q_empty),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

### sv/mqpf_front.sv
// ----------------------------------------------------------------------------
// mqpf_front
// accepts items, checks them against the packet state and issues commands
// ----------------------------------------------------------------------------
module mqpf_front
    import mqpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  item_t       item,
    input  logic [28:0] buffer_limit,
    output logic        cmd_push,
    output cmd_t        cmd
);

    logic        open_reg;
    logic        open_next;
    logic [27:0] left_reg;
    logic [27:0] left_next;

    logic [28:0] rem;
    logic [1:0]  nlen_m1;
    logic [28:0] total;
    logic [27:0] left_m1;

    assign rem     = 29'd2 + {13'b0, item.topic_bytes} + {1'b0, item.payload_bytes};
    assign left_m1 = left_reg - 28'd1;
    assign total   = rem + {27'b0, nlen_m1} + 29'd2;

    always_comb
    begin
        if (rem < RL_ONE_BYTE)
            nlen_m1 = 2'd0;
        else if (rem < RL_TWO_BYTE)
            nlen_m1 = 2'd1;
        else if (rem < RL_THREE_BYTE)
            nlen_m1 = 2'd2;
        else
            nlen_m1 = 2'd3;
    end

    always_comb
    begin
        open_next       = open_reg;
        left_next       = left_reg;
        cmd_push        = 1'b0;
        cmd.kind        = CMD_ERR;
        cmd.dbyte       = item.data_byte;
        cmd.last        = 1'b1;
        cmd.status      = ST_OK;
        cmd.rem         = rem[27:0];
        cmd.nlen_m1     = nlen_m1;
        cmd.topic_bytes = item.topic_bytes;
        if (item_valid)
        begin
            unique case (item.action)
                ACT_DATA:
                begin
                    cmd_push = 1'b1;
                    if (!open_reg)
                        cmd.status = ST_SEQ;
                    else
                    begin
                        cmd.kind  = CMD_DATA;
                        cmd.last  = (left_m1 == 28'd0);
                        left_next = left_m1;
                        open_next = (left_m1 != 28'd0);
                    end
                end
                ACT_START, ACT_DISC:
                begin
                    cmd_push = 1'b1;
                    if (open_reg)
                    begin
                        // abandon the open packet
                        cmd.status = ST_SEQ;
                        open_next  = 1'b0;
                        left_next  = 28'd0;
                    end
                    else if (item.action == ACT_DISC)
                    begin
                        if (buffer_limit < 29'd2)
                            cmd.status = ST_LONG;
                        else
                            cmd.kind = CMD_DISC;
                    end
                    else if (item.topic_bytes == 16'd0)
                        cmd.status = ST_EMPTY;
                    else if (rem > RL_MAX || total > buffer_limit)
                        cmd.status = ST_LONG;
                    else
                    begin
                        cmd.kind  = CMD_START;
                        cmd.dbyte = {7'b0, item.retained};
                        open_next = 1'b1;
                        left_next = 28'(rem - 29'd2);
                    end
                end
                default:
                begin
                    cmd_push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
            left_reg <= 28'd0;
        end
        else
        begin
            open_reg <= open_next;
            left_reg <= left_next;
        end
    end

endmodule

### sv/mqpf_cmd_queue.sv
// ----------------------------------------------------------------------------
// mqpf_cmd_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module mqpf_cmd_queue
    import mqpf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic full,
    output logic empty
);

    localparam int PW = $clog2(CMD_DEPTH);
    localparam int CW = $clog2(CMD_DEPTH + 1);

    cmd_t          mem_reg [CMD_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr;
    logic          do_rd;

    assign full    = (count_reg == CW'(CMD_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= PW'((32'(wr_ptr_reg) + 1) % CMD_DEPTH);
            if (do_rd)
                rd_ptr_reg <= PW'((32'(rd_ptr_reg) + 1) % CMD_DEPTH);
            if (do_wr && !do_rd)
                count_reg <= count_reg + CW'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - CW'(1);
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CMD_DEPTH))
        else $error("command queue count over depth");
    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + CW'(1)))
        else $error("command queue count not raised on write");
    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        (do_rd && !do_wr) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("command queue count not lowered on read");
`endif

endmodule

### sv/mqpf_back.sv
// ----------------------------------------------------------------------------
// mqpf_back
// expands commands into packet bytes behind an output register
// ----------------------------------------------------------------------------
module mqpf_back
    import mqpf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cmd_valid,
    input  cmd_t    cmd,
    output logic    cmd_pop,
    output result_t result,
    output logic    empty,
    input  logic    pop
);

    logic [2:0] step_reg;
    logic [2:0] step_next;
    logic       out_valid_reg;
    result_t    out_reg;

    result_t    cur;
    logic       final_step;
    logic       advance;
    logic       load;
    logic [1:0] idx;
    logic [6:0] grp;

    assign advance = !out_valid_reg || pop;
    assign load    = advance && cmd_valid;
    assign cmd_pop = load && final_step;
    assign idx     = 2'(step_reg - 3'd1);
    assign result  = out_reg;
    assign empty   = !out_valid_reg;

    always_comb
    begin
        case (idx)
            2'd0:    grp = cmd.rem[6:0];
            2'd1:    grp = cmd.rem[13:7];
            2'd2:    grp = cmd.rem[20:14];
            default: grp = cmd.rem[27:21];
        endcase
    end

    always_comb
    begin
        cur.out_byte = 8'd0;
        cur.last     = 1'b0;
        cur.status   = ST_OK;
        final_step   = 1'b0;
        unique case (cmd.kind)
            CMD_DATA:
            begin
                cur.out_byte = cmd.dbyte;
                cur.last     = cmd.last;
                final_step   = 1'b1;
            end
            CMD_ERR:
            begin
                cur.last   = 1'b1;
                cur.status = cmd.status;
                final_step = 1'b1;
            end
            CMD_DISC:
            begin
                if (step_reg == 3'd0)
                    cur.out_byte = HDR_DISC;
                else
                begin
                    cur.last   = 1'b1;
                    final_step = 1'b1;
                end
            end
            CMD_START:
            begin
                if (step_reg == 3'd0)
                    cur.out_byte = HDR_PUBLISH | {7'b0, cmd.dbyte[0]};
                else if (step_reg <= {1'b0, cmd.nlen_m1} + 3'd1)
                    cur.out_byte = {idx != cmd.nlen_m1, grp};
                else if (step_reg == {1'b0, cmd.nlen_m1} + 3'd2)
                    cur.out_byte = cmd.topic_bytes[15:8];
                else
                begin
                    // data bytes still follow, so not the packet end
                    cur.out_byte = cmd.topic_bytes[7:0];
                    final_step   = 1'b1;
                end
            end
            default:
            begin
                final_step = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        step_next = step_reg;
        if (load)
            step_next = final_step ? 3'd0 : step_reg + 3'd1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (advance)
                out_valid_reg <= cmd_valid;
        end
    end

`ifndef NO_ASSERTIONS
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= 3'd6)
        else $error("sequencer step out of range");
    a_step_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |=> (step_reg == 3'd0))
        else $error("sequencer step not cleared after command");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> (out_valid_reg && $stable(out_reg)))
        else $error("waiting result changed without transfer");
`endif

endmodule

### dv/mqpf_frame_checker.sv
// ----------------------------------------------------------------------------
// mqpf_frame_checker
// predicts the framed byte stream of every item transfer and checks each
// result transfer of the mqtt publish packet framer against it
// ----------------------------------------------------------------------------
module mqpf_frame_checker
    import mqpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  item_t       item,
    input  logic        empty,
    input  logic        pop,
    input  result_t     result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          mismatches,
    output int          pending,
    output int          results_checked
);

    localparam int REPORT_MAX = 10;

    // framer state as predicted
    logic        in_packet;
    logic [27:0] bytes_owed;
    logic [28:0] limit_bytes;

    result_t     frame_bytes[$];

    function automatic void queue_byte(logic [7:0] b, logic l, logic [1:0] st);
        result_t r;
        r.out_byte = b;
        r.last     = l;
        r.status   = st;
        frame_bytes.push_back(r);
    endfunction

    task automatic frame_item(input item_t it);
        logic [28:0] rem_len;
        logic [28:0] rest;
        logic [29:0] total;
        logic [2:0]  nlen;
        logic [7:0]  b;
        case (it.action)
            ACT_DATA:
            begin
                if (!in_packet)
                    queue_byte(8'h00, 1'b1, ST_SEQ);
                else
                begin
                    bytes_owed = bytes_owed - 28'd1;
                    if (bytes_owed == '0)
                        in_packet = 1'b0;
                    queue_byte(it.data_byte, bytes_owed == '0, ST_OK);
                end
            end
            ACT_START, ACT_DISC:
            begin
                // start or disconnect inside a packet drops that packet
                if (in_packet)
                begin
                    in_packet  = 1'b0;
                    bytes_owed = '0;
                    queue_byte(8'h00, 1'b1, ST_SEQ);
                end
                else if (it.action == ACT_DISC)
                begin
                    if (limit_bytes < 29'd2)
                        queue_byte(8'h00, 1'b1, ST_LONG);
                    else
                    begin
                        queue_byte(HDR_DISC, 1'b0, ST_OK);
                        queue_byte(8'h00, 1'b1, ST_OK);
                    end
                end
                else if (it.topic_bytes == '0)
                    queue_byte(8'h00, 1'b1, ST_EMPTY);
                else
                begin
                    rem_len = 29'd2 + it.topic_bytes + it.payload_bytes;
                    nlen = (rem_len < RL_ONE_BYTE) ? 3'd1 :
                           (rem_len < RL_TWO_BYTE) ? 3'd2 :
                           (rem_len < RL_THREE_BYTE) ? 3'd3 : 3'd4;
                    total = 30'd1 + nlen + rem_len;
                    if (rem_len > RL_MAX || total > limit_bytes)
                        queue_byte(8'h00, 1'b1, ST_LONG);
                    else
                    begin
                        queue_byte(HDR_PUBLISH | {7'd0, it.retained}, 1'b0, ST_OK);
                        rest = rem_len;
                        do
                        begin
                            b = {1'b0, rest[6:0]};
                            rest = rest >> 7;
                            if (rest != '0)
                                b[7] = 1'b1;
                            queue_byte(b, 1'b0, ST_OK);
                        end
                        while (rest != '0);
                        queue_byte(it.topic_bytes[15:8], 1'b0, ST_OK);
                        queue_byte(it.topic_bytes[7:0], 1'b0, ST_OK);
                        bytes_owed = it.payload_bytes + 28'(it.topic_bytes);
                        in_packet  = 1'b1;
                    end
                end
            end
            default:
                ;   // unused action, nothing framed
        endcase
    endtask

    task automatic check_byte(input result_t got);
        result_t want;
        results_checked++;
        if (frame_bytes.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("result with nothing outstanding: byte %02h last %0b status %0d",
                         got.out_byte, got.last, got.status);
        end
        else
        begin
            want = frame_bytes.pop_front();
            if (got.out_byte != want.out_byte || got.last != want.last ||
                got.status != want.status)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("byte %0d: want %02h last %0b status %0d, got %02h last %0b status %0d",
                             results_checked, want.out_byte, want.last, want.status,
                             got.out_byte, got.last, got.status);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_packet       = 1'b0;
            bytes_owed      = '0;
            limit_bytes     = LIMIT_RESET;
            frame_bytes.delete();
            mismatches      = 0;
            pending         = 0;
            results_checked = 0;
        end
        else
        begin
            // an item never yields a byte at its own transfer edge
            if (pop && !empty)
                check_byte(result);
            if (psel && penable && pwrite && pready && paddr[2] == REG_BUFFER_LIMIT)
                limit_bytes = pwdata[28:0];
            if (push && !full)
                frame_item(item);
            pending = frame_bytes.size();
        end
    end

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives the mqtt publish packet framer with directed edge packets and
// random packet streams under several buffer limits; a checker beside the
// block predicts every byte and this top gives the verdict
// ----------------------------------------------------------------------------
module tb_top;
    import mqpf_pkg::*;

    // action code the framer ignores
    localparam logic [1:0]  ACT_NONE    = 2'd3;
    // apb byte addresses: the limit register and an unmapped slot
    localparam logic [2:0]  ADDR_LIMIT  = {REG_BUFFER_LIMIT, 2'b00};
    localparam logic [2:0]  ADDR_UNUSED = 3'd4;
    localparam logic [28:0] LIMIT_MAX   = 29'd268435460;
    // cycles with no transfer at all before the run is declared hung
    localparam int          STALL_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    item_t       item;
    logic        empty;
    logic        pop;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int mismatches;
    int pending;
    int results_checked;

    // stimulus bookkeeping
    int items_sent;
    int ignored_items;
    int publishes;
    int reg_writes;
    int limit_now;
    int idle_cycles = 0;

    // calm: a stretch with no idling on either side; tail: the last phase
    logic calm = 1'b0;
    logic tail;

    mqtt_publish_packet_framer i_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    mqpf_frame_checker i_checker
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .item            (item),
        .empty           (empty),
        .pop             (pop),
        .result          (result),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // toggle between idling and calm stretches now and then
    always @(posedge clk)
    begin
        if ($urandom_range(0, 39) == 0)
            calm <= !calm;
    end

    // result side: pop high except for random stall bursts
    initial
    begin : pop_drive
        int stall;
        stall = 0;
        pop   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                pop <= 1'b0;
                stall--;
            end
            else if (!calm && !tail && $urandom_range(0, 4) == 0)
            begin
                pop <= 1'b0;
                stall = $urandom_range(1, 4) - 1;
            end
            else
                pop <= 1'b1;
        end
    end

    // watchdog: any item, result or register transfer counts as progress
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || (psel && penable && pwrite))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("no transfer for %0d cycles, %0d bytes outstanding",
                     STALL_LIMIT, pending);
            $display("FAIL mqtt_publish_packet_framer");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // all fields random so that unused fields also toggle
    function automatic item_t make_item(logic [1:0] act);
        item_t it;
        it.action        = act;
        it.topic_bytes   = 16'($urandom);
        it.payload_bytes = 28'($urandom);
        it.retained      = 1'($urandom);
        it.data_byte     = 8'($urandom);
        return it;
    endfunction

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_item(input item_t it);
        int gap;
        if (!calm && !tail && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 4);
            repeat (gap)
            begin
                push <= 1'b0;
                item <= make_item(2'($urandom));
                @(negedge clk);
            end
        end
        push <= 1'b1;
        item <= it;
        // full only moves at the rising edge, so it is stable here
        while (full)
            @(negedge clk);
        @(posedge clk);
        if (it.action == ACT_NONE)
            ignored_items++;
        else
            items_sent++;
        @(negedge clk);
    endtask

    // start item then `sent` data bytes; fewer bytes than owed leave it open
    task automatic publish(input int tlen, input int plen, input int sent);
        item_t it;
        it = make_item(ACT_START);
        it.topic_bytes   = tlen[15:0];
        it.payload_bytes = plen[27:0];
        send_item(it);
        publishes++;
        repeat (sent)
            send_item(make_item(ACT_DATA));
    endtask

    // drain: every predicted byte has come out, then idle before touching
    // the register
    task automatic settle;
        push <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (CMD_DEPTH * 2 + 4)
            @(negedge clk);
    endtask

    // apb write: setup cycle, access cycle, pready is tied high
    task automatic put_reg(input logic [2:0] addr, input logic [28:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {3'b000, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_writes++;
        if (addr == ADDR_LIMIT)
            limit_now = value;
    endtask

    // mostly well-formed packets with random content, the rest broken
    // sequences and noise, until the item count reaches goal
    task automatic random_phase(input int goal);
        int pick;
        int t;
        int p;
        int room;
        while (items_sent < goal)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
            begin
                // complete packet sized to fit the current limit
                room = (limit_now > 24) ? 20 : limit_now - 4;
                if (room < 1)
                begin
                    t = 1;
                    p = 0;
                end
                else
                begin
                    t = $urandom_range(1, (room < 6) ? room : 6);
                    p = $urandom_range(0, room - t);
                end
                publish(t, p, t + p);
            end
            else if (pick < 70)
                send_item(make_item(ACT_DISC));
            else if (pick < 78)
                publish($urandom_range(1, 20), $urandom_range(0, 40), $urandom_range(0, 2));
            else if (pick < 86)
                // wide lengths: multi-byte headers or too long
                publish($urandom_range(0, 65535), $urandom_range(0, 28'hFFFFFFF),
                        $urandom_range(0, 2));
            else if (pick < 92)
                send_item(make_item(ACT_DATA));
            else if (pick < 96)
                send_item(make_item(ACT_NONE));
            else
                publish(0, $urandom_range(0, 100), 0);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        push          = 1'b0;
        item          = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        tail          = 1'b0;
        items_sent    = 0;
        ignored_items = 0;
        publishes     = 0;
        reg_writes    = 0;
        limit_now     = LIMIT_RESET;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part at the reset limit of 1460
        send_item(make_item(ACT_DATA));         // data with no packet open
        send_item(make_item(ACT_NONE));         // ignored action
        publish(0, 7, 0);                       // empty topic
        publish(1, 0, 1);                       // smallest packet
        send_item(make_item(ACT_DISC));
        publish(65535, 28'hFFFFFFF, 0);         // remaining length overflow
        publish(1, 1454, 1);                    // total exactly at the limit
        send_item(make_item(ACT_DISC));         // disconnect drops open packet
        publish(1, 1455, 0);                    // one byte over the limit
        publish(1, 124, 0);                     // largest one-byte length
        publish(1, 125, 0);                     // start drops open packet
        publish(1, 125, 2);                     // smallest two-byte length
        publish(2, 3, 0);
        send_item(make_item(ACT_DISC));
        settle();

        put_reg(ADDR_LIMIT, LIMIT_MAX);
        publish(1, int'(RL_MAX) - 3, 1);        // largest remaining length, four bytes
        publish(2, int'(RL_MAX) - 3, 0);
        publish(2, int'(RL_MAX) - 3, 0);        // one past the largest
        publish(300, 20000, 0);                 // three-byte length
        send_item(make_item(ACT_DISC));
        settle();

        // disconnect against the smallest limits, and a write to no register
        put_reg(ADDR_LIMIT, 29'd1);
        send_item(make_item(ACT_DISC));
        settle();
        put_reg(ADDR_UNUSED, 29'd500);
        send_item(make_item(ACT_DISC));
        settle();
        put_reg(ADDR_LIMIT, 29'd2);
        send_item(make_item(ACT_DISC));
        publish(1, 0, 0);
        settle();

        // random phases, each under its own limit
        put_reg(ADDR_LIMIT, LIMIT_RESET);
        random_phase(90);
        settle();
        put_reg(ADDR_LIMIT, 29'($urandom_range(5, 60)));
        random_phase(150);
        settle();
        put_reg(ADDR_LIMIT, LIMIT_MAX);
        random_phase(210);
        settle();
        put_reg(ADDR_LIMIT, 29'($urandom_range(16384, 3000000)));
        tail <= 1'b1;
        random_phase(270);
        settle();

        $display("covered %0d items (%0d publish starts) plus %0d ignored, %0d register writes",
                 items_sent, publishes, ignored_items, reg_writes);
        $display("checked %0d result bytes under limits from 1 up to %0d",
                 results_checked, LIMIT_MAX);
        if (mismatches == 0 && pending == 0)
            $display("PASS mqtt_publish_packet_framer");
        else
            $display("FAIL mqtt_publish_packet_framer");
        $finish;
    end

endmodule
